@@ design/gwc_pkg.sv @@
// Shared widths, register indexes and pipeline word types for the grid wrap/clip indexer.
package gwc_pkg;

  // Grid shape
  localparam int NumDims    = 4;
  localparam int MaxDivs    = 256;
  localparam int CoordW     = 16;
  localparam int DivsW      = 9;
  localparam int FixedW     = 8;
  localparam int IndexW     = 32;
  localparam int WrapW      = NumDims;

  // Pipeline depth: one remainder bit per cell, one Horner step per cell
  localparam int ModStages  = CoordW;
  localparam int MacStages  = NumDims;
  localparam int ChainLen   = ModStages + MacStages;

  // Configuration port
  localparam int CfgIndexW  = 3;
  localparam int CfgDataW   = DivsW;

  localparam logic [CfgIndexW-1:0] RegDivsDim0 = 3'd0;
  localparam logic [CfgIndexW-1:0] RegDivsDim1 = 3'd1;
  localparam logic [CfgIndexW-1:0] RegDivsDim2 = 3'd2;
  localparam logic [CfgIndexW-1:0] RegDivsDim3 = 3'd3;
  localparam logic [CfgIndexW-1:0] RegWrapMask = 3'd4;

  localparam logic [DivsW-1:0] DivsReset = 9'd16;
  localparam logic [WrapW-1:0] WrapReset = '0;

  // Stream word widths
  localparam int InDataW  = NumDims * CoordW;
  localparam int OutDataW = IndexW + NumDims * FixedW;

  typedef logic [NumDims-1:0][DivsW-1:0] divs_arr_t;

  // One lane of the remainder chain
  typedef struct packed {
    logic              neg;   // coordinate was negative
    logic [CoordW-1:0] mag;   // magnitude bits still to shift in, MSB first
    logic [FixedW-1:0] rem;   // partial remainder, always below the divisor
    logic [FixedW-1:0] clip;  // clipped coordinate for a non-wrapping lane
  } lane_t;

  typedef lane_t [NumDims-1:0] mod_word_t;

  // Word of the Horner chain
  typedef struct packed {
    logic [NumDims-1:0][FixedW-1:0] fixed;
    logic [IndexW-1:0]              acc;
  } idx_word_t;

endpackage

@@ design/grid_wrap_clip_linear_index.sv @@
// Top level: configuration registers, the remainder cell row, the Horner cell row and the stream ports.
//
// Takes one word of four signed 16-bit grid coordinates and returns the wrapped or
// clipped coordinates and their row-major linear index (dimension 0 fastest). A new word
// is accepted every cycle while the output is not stalled; the pipeline is the row of 16
// remainder cells (one magnitude bit per cell, all four lanes side by side) followed by
// 4 multiply-add cells (one dimension per cell). Every cell holds its word until the next
// one frees up, so the input keeps flowing while a result waits at the output until all
// 20 cells hold a word. A division
// count of 0 acts as 1 and counts above 256 act as 256. The division counts are read directly
// by all cells and the wrap mask between the rows, so write them only while no word is in flight.
module grid_wrap_clip_linear_index (
  input  logic                            clk,
  input  logic                            rst,
  // Input stream: coord_dim0, coord_dim1, coord_dim2, coord_dim3 (16 bits each, signed)
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [gwc_pkg::InDataW-1:0]     s_axis_tdata,
  // Output stream: state_index (32), fixed_dim0, fixed_dim1, fixed_dim2, fixed_dim3 (8 each)
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [gwc_pkg::OutDataW-1:0]    m_axis_tdata,
  // Configuration write channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [gwc_pkg::CfgIndexW-1:0]   cfg_index,
  input  logic [gwc_pkg::CfgDataW-1:0]    cfg_data
);
  import gwc_pkg::*;

  divs_arr_t        divs_reg;
  logic [WrapW-1:0] wrap_mask;
  divs_arr_t        divs_eff;

  logic [ChainLen:0] v;
  logic [ChainLen:0] r;
  mod_word_t         mw [ModStages+1];
  idx_word_t         aw [MacStages+1];

  logic in_acc;
  logic out_acc;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int d = 0; d < NumDims; d++) begin
        divs_reg[d] <= DivsReset;
      end
      wrap_mask <= WrapReset;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        RegDivsDim0: divs_reg[0] <= cfg_data[DivsW-1:0];
        RegDivsDim1: divs_reg[1] <= cfg_data[DivsW-1:0];
        RegDivsDim2: divs_reg[2] <= cfg_data[DivsW-1:0];
        RegDivsDim3: divs_reg[3] <= cfg_data[DivsW-1:0];
        RegWrapMask: wrap_mask   <= cfg_data[WrapW-1:0];
        default: ;
      endcase
    end
  end

  // Saturate division counts into 1..MaxDivs
  always_comb begin
    for (int d = 0; d < NumDims; d++) begin
      priority if (divs_reg[d] == '0) begin
        divs_eff[d] = DivsW'(1);
      end else if (divs_reg[d] > DivsW'(MaxDivs)) begin
        divs_eff[d] = DivsW'(MaxDivs);
      end else begin
        divs_eff[d] = divs_reg[d];
      end
    end
  end

  // Split sign and magnitude, and work out the clipped value up front
  always_comb begin
    logic [CoordW-1:0] c;
    c = '0;
    for (int l = 0; l < NumDims; l++) begin
      c           = s_axis_tdata[l*CoordW +: CoordW];
      mw[0][l].neg = c[CoordW-1];
      mw[0][l].mag = c[CoordW-1] ? CoordW'(-c) : c;
      mw[0][l].rem = '0;
      priority if (c[CoordW-1]) begin
        mw[0][l].clip = '0;
      end else if (c >= CoordW'(divs_eff[l])) begin
        mw[0][l].clip = FixedW'(divs_eff[l] - DivsW'(1));
      end else begin
        mw[0][l].clip = c[FixedW-1:0];
      end
    end
  end

  assign v[0]          = s_axis_tvalid;
  assign s_axis_tready = r[0];

  // Remainder cell row
  for (genvar i = 0; i < ModStages; i++) begin : g_mod
    gwc_mod_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (v[i]),
      .in_ready  (r[i]),
      .in_word   (mw[i]),
      .divs      (divs_eff),
      .out_valid (v[i+1]),
      .out_ready (r[i+1]),
      .out_word  (mw[i+1])
    );
  end

  // Turn remainders into floor-mod results, or take the clipped value
  always_comb begin
    aw[0].acc = '0;
    for (int l = 0; l < NumDims; l++) begin
      if (!wrap_mask[l]) begin
        aw[0].fixed[l] = mw[ModStages][l].clip;
      end else if (mw[ModStages][l].neg && (mw[ModStages][l].rem != '0)) begin
        aw[0].fixed[l] = FixedW'(divs_eff[l] - DivsW'(mw[ModStages][l].rem));
      end else begin
        aw[0].fixed[l] = mw[ModStages][l].rem;
      end
    end
  end

  // Horner cell row, highest dimension first
  for (genvar j = 0; j < MacStages; j++) begin : g_mac
    gwc_mac_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (v[ModStages+j]),
      .in_ready  (r[ModStages+j]),
      .in_word   (aw[j]),
      .divs      (divs_eff[NumDims-1-j]),
      .fixed     (aw[j].fixed[NumDims-1-j]),
      .out_valid (v[ModStages+j+1]),
      .out_ready (r[ModStages+j+1]),
      .out_word  (aw[j+1])
    );
  end

  // Output word
  assign m_axis_tvalid = v[ChainLen];
  assign r[ChainLen]   = m_axis_tready;
  assign m_axis_tdata  = {aw[MacStages].fixed, aw[MacStages].acc};

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  // An accepted word lands in the first remainder cell
  a_entry_lands: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> v[1])
    else $error("accepted word missing from first remainder cell");

  // A word handed from the remainder row lands in the first Horner cell
  a_handoff_lands: assert property (@(posedge clk) disable iff (rst)
    (v[ModStages] && r[ModStages]) |=> v[ModStages+1])
    else $error("word lost between remainder and Horner rows");

  // Occupancy changes only by words accepted and words delivered
  a_occupancy: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> ($countones(v[ChainLen:1]) ==
      $past($countones(v[ChainLen:1])) + int'($past(in_acc)) - int'($past(out_acc))))
    else $error("cell row dropped or duplicated a word");

endmodule

@@ design/gwc_mod_cell.sv @@
// One restoring remainder step for every lane, registered, with bubble-collapsing flow control.
module gwc_mod_cell (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  gwc_pkg::mod_word_t in_word,
  input  gwc_pkg::divs_arr_t divs,
  output logic               out_valid,
  input  logic               out_ready,
  output gwc_pkg::mod_word_t out_word
);
  import gwc_pkg::*;

  mod_word_t out_word_next;

  // Shift in the next magnitude bit and subtract the divisor when it fits
  always_comb begin
    logic [FixedW:0] trial;
    trial = '0;
    out_word_next = in_word;
    for (int l = 0; l < NumDims; l++) begin
      trial                = {in_word[l].rem, in_word[l].mag[CoordW-1]};
      out_word_next[l].mag = {in_word[l].mag[CoordW-2:0], 1'b0};
      if (trial >= divs[l]) begin
        out_word_next[l].rem = FixedW'(trial - divs[l]);
      end else begin
        out_word_next[l].rem = trial[FixedW-1:0];
      end
    end
  end

  // Take a word when empty or when the held word moves on
  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_word <= out_word_next;
    end
  end

endmodule

@@ design/gwc_mac_cell.sv @@
// One Horner step acc * divs + fixed, registered, with bubble-collapsing flow control.
module gwc_mac_cell (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  gwc_pkg::idx_word_t           in_word,
  input  logic [gwc_pkg::DivsW-1:0]    divs,
  input  logic [gwc_pkg::FixedW-1:0]   fixed,
  output logic                         out_valid,
  input  logic                         out_ready,
  output gwc_pkg::idx_word_t           out_word
);
  import gwc_pkg::*;

  logic [IndexW-1:0] prod;
  idx_word_t         out_word_next;

  // Scale the running index by this dimension and add its coordinate
  always_comb begin
    prod              = in_word.acc * IndexW'(divs);
    out_word_next     = in_word;
    out_word_next.acc = prod + IndexW'(fixed);
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_word <= out_word_next;
    end
  end

endmodule

@@ test/grid_wrap_clip_linear_index_tb.sv @@
// Self-checking stream testbench for the grid coordinate wrap/clip and linear index block.
module grid_wrap_clip_linear_index_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import gwc_pkg::*;

  localparam int WatchdogLimit = 1000;

  typedef logic [NumDims-1:0][CoordW-1:0] coord_set_t;

  // Packed so that it lines up with the output word: index low, fixed_dim0 next
  typedef struct packed {
    logic [NumDims-1:0][FixedW-1:0] fixed;
    logic [IndexW-1:0]              state_index;
  } grid_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [InDataW-1:0]    s_axis_tdata = '0;   // coord_dim0, coord_dim1, coord_dim2, coord_dim3
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OutDataW-1:0]   m_axis_tdata;        // state_index, fixed_dim0 .. fixed_dim3
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CfgIndexW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0]   cfg_data = '0;

  // Shadow copy of the configuration registers
  logic [DivsW-1:0]      divs_shadow [NumDims];
  logic [WrapW-1:0]      wrap_shadow;

  grid_result_t          pending_results [$];
  int                    fail_count = 0;
  int                    idle_pct = 0;
  int                    stall_left = 0;
  int                    quiet_cycles = 0;

  always #5 clk = ~clk;

  grid_wrap_clip_linear_index dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    for (int i = 0; i < NumDims; i++) divs_shadow[i] = DivsReset;
    wrap_shadow = WrapReset;
  end

  // Division count as the block uses it: zero acts as one, large counts saturate
  function automatic int effective_divs(int dim);
    int d;
    d = int'(divs_shadow[dim[1:0]]);
    if (d == 0) d = 1;
    if (d > MaxDivs) d = MaxDivs;
    return d;
  endfunction

  // Fold each coordinate into its grid, then Horner-accumulate with dim 0 fastest
  function automatic grid_result_t predict_grid(coord_set_t coords);
    grid_result_t r;
    int span;
    int c;
    int f;
    logic [63:0] acc;
    acc = '0;
    for (int i = 0; i < NumDims; i++) begin
      span = effective_divs(i);
      c = int'($signed(coords[i]));
      if (wrap_shadow[i]) begin
        f = c % span;
        if (f < 0) f += span;
      end else if (c < 0) begin
        f = 0;
      end else if (c >= span) begin
        f = span - 1;
      end else begin
        f = c;
      end
      r.fixed[i] = f[FixedW-1:0];
    end
    for (int i = NumDims - 1; i >= 0; i--) begin
      acc = acc * 64'(effective_divs(i)) + 64'(r.fixed[i]);
    end
    r.state_index = acc[IndexW-1:0];
    return r;
  endfunction

  function automatic coord_set_t pack_coords(int c0, int c1, int c2, int c3);
    coord_set_t s;
    s[0] = c0[CoordW-1:0];
    s[1] = c1[CoordW-1:0];
    s[2] = c2[CoordW-1:0];
    s[3] = c3[CoordW-1:0];
    return s;
  endfunction

  // Mix of full-range values, values around the grid and the coordinate extremes
  function automatic coord_set_t random_coords();
    coord_set_t s;
    int span;
    int v;
    for (int i = 0; i < NumDims; i++) begin
      span = effective_divs(i);
      case ($urandom_range(0, 9))
        0, 1, 2: v = int'($urandom_range(0, 65535));
        8:       v = $urandom_range(0, 1) ? 32767 : -32768;
        9:       v = span * int'($urandom_range(0, 4)) - int'($urandom_range(0, 1));
        default: v = int'($urandom_range(0, 4 * span + 2)) - 2 * span - 1;
      endcase
      s[i] = v[CoordW-1:0];
    end
    return s;
  endfunction

  function automatic logic [CfgDataW-1:0] pick_divs();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 9'd1;
      2:       return 9'd256;
      3:       return 9'($urandom_range(257, 511));
      4, 5:    return 9'($urandom_range(2, 16));
      default: return 9'($urandom_range(1, 256));
    endcase
  endfunction

  // Output side: random bursts of stalls on tready
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      stall_left <= $urandom_range(0, 11);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Compare each output word with the oldest pending result
  always @(posedge clk) begin
    grid_result_t want;
    grid_result_t got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = grid_result_t'(m_axis_tdata);
      if (pending_results.size() == 0) begin
        $error("unexpected output word: state_index %0d", got.state_index);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (got.state_index !== want.state_index) begin
          $error("state_index expected %0d actual %0d", want.state_index, got.state_index);
          fail_count++;
        end
        for (int i = 0; i < NumDims; i++) begin
          if (got.fixed[i] !== want.fixed[i]) begin
            $error("fixed_dim%0d expected %0d actual %0d", i, want.fixed[i], got.fixed[i]);
            fail_count++;
          end
        end
      end
    end
  end

  // End the run when no handshake completes for too long
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WatchdogLimit) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Write one register; hold valid high unless this is the last write of a group
  task automatic write_reg(input logic [CfgIndexW-1:0] idx, input logic [CfgDataW-1:0] value,
                           input bit last);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    if (last) cfg_valid <= 1'b0;
    case (idx)
      RegDivsDim0, RegDivsDim1, RegDivsDim2, RegDivsDim3: divs_shadow[idx[1:0]] = value;
      RegWrapMask: wrap_shadow = value[WrapW-1:0];
      default: ;
    endcase
  endtask

  task automatic load_shape(input logic [CfgDataW-1:0] d0, input logic [CfgDataW-1:0] d1,
                            input logic [CfgDataW-1:0] d2, input logic [CfgDataW-1:0] d3,
                            input logic [CfgDataW-1:0] wrap);
    write_reg(RegDivsDim0, d0, 1'b0);
    write_reg(RegDivsDim1, d1, 1'b0);
    write_reg(RegDivsDim2, d2, 1'b0);
    write_reg(RegDivsDim3, d3, 1'b0);
    write_reg(RegWrapMask, wrap, 1'b1);
  endtask

  // Send one input word, with an optional idle burst ahead of it
  task automatic send_word(input coord_set_t coords);
    int gap;
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      gap = $urandom_range(1, 12);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= coords;
    do @(posedge clk); while (!s_axis_tready);
    pending_results.push_back(predict_grid(coords));
  endtask

  // Hold the input off until every pending result has come back
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // Reset shape: 16 divisions everywhere, all dimensions clip
  task automatic test_reset_shape();
    idle_pct = 20;
    send_word(pack_coords(0, 0, 0, 0));
    send_word(pack_coords(15, 15, 15, 15));
    send_word(pack_coords(16, -1, 32767, -32768));
    send_word(pack_coords(-32768, 32767, -1, 16));
    drain_results();
  endtask

  // Full-size grid, clipping then wrapping; covers the largest index
  task automatic test_extreme_shapes();
    load_shape(9'd256, 9'd256, 9'd256, 9'd256, 9'd0);
    send_word(pack_coords(255, 255, 255, 255));
    send_word(pack_coords(32767, 32767, 32767, 32767));
    send_word(pack_coords(-1, -1, -1, -1));
    drain_results();
    load_shape(9'd256, 9'd256, 9'd256, 9'd256, 9'd15);
    send_word(pack_coords(-1, -32768, 32767, 256));
    send_word(pack_coords(-257, 255, 0, -256));
    drain_results();
  endtask

  // Zero and oversized division counts, and mixed wrap/clip masks
  task automatic test_mixed_modes();
    load_shape(9'd0, 9'd511, 9'd257, 9'd1, 9'b0101);
    send_word(pack_coords(5, -5, 300, 7));
    send_word(pack_coords(-32768, 32767, -1, -1));
    send_word(pack_coords(32767, -32768, 255, 0));
    drain_results();
    load_shape(9'd3, 9'd7, 9'd100, 9'd13, 9'b1010);
    send_word(pack_coords(-1, -1, -1, -1));
    send_word(pack_coords(-3, -7, -100, -13));
    send_word(pack_coords(2, 6, 99, 12));
    send_word(pack_coords(3, 7, 100, 13));
    send_word(pack_coords(-32768, -32768, -32768, -32768));
    send_word(pack_coords(32767, 32767, 32767, 32767));
    drain_results();
  endtask

  // Upper wrap data bits and writes past the last register must change nothing
  task automatic test_unmapped_registers();
    write_reg(RegWrapMask, 9'h1F3, 1'b0);
    for (int k = RegWrapMask + 1; k < 2 ** CfgIndexW; k++) begin
      write_reg(CfgIndexW'(k), 9'h1FF, k == 2 ** CfgIndexW - 1);
    end
    send_word(pack_coords(-2, 20, 300, -9));
    send_word(pack_coords(1000, -1000, 5, 5));
    drain_results();
  endtask

  // Random grid shapes with random traffic and varying idle density
  task automatic test_random_shapes();
    for (int phase = 0; phase < 12; phase++) begin
      drain_results();
      load_shape(pick_divs(), pick_divs(), pick_divs(), pick_divs(),
                 9'($urandom_range(0, 511)));
      idle_pct = (phase % 3 == 0) ? 0 : (phase % 3 == 1) ? 15 : 40;
      for (int n = 0; n < 110; n++) begin
        if (n == 55 && phase % 4 == 1) drain_results();
        send_word(random_coords());
      end
    end
  endtask

  // Closing stretch at full rate on both sides
  task automatic test_back_to_back();
    drain_results();
    idle_pct = 0;
    load_shape(pick_divs(), pick_divs(), pick_divs(), pick_divs(),
               9'($urandom_range(0, 15)));
    for (int n = 0; n < 100; n++) send_word(random_coords());
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_reset_shape();
    test_extreme_shapes();
    test_mixed_modes();
    test_unmapped_registers();
    test_random_shapes();
    test_back_to_back();
    drain_results();
    repeat (2 * ChainLen) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/gwc_pkg.sv
design/gwc_mod_cell.sv
design/gwc_mac_cell.sv
design/grid_wrap_clip_linear_index.sv
test/grid_wrap_clip_linear_index_tb.sv
